@@ rtl/ipv6c_pkg.sv @@
// ipv6c_pkg: shared types and constants for the ipv6 address text compressor
// holds the input/result payload structs and the group unit status struct
// no dependencies
package ipv6c_pkg;

  localparam int unsigned NumGroups = 8;

  // ascii codes
  localparam logic [6:0] CharColon = 7'h3A;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharAlpha = 7'h57;  // 'a' minus ten

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } in_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } out_t;

  // status of the currently selected group
  typedef struct packed {
    logic       zero;       // whole group is zero
    logic [1:0] pos;        // nibble index that was turned into text_char
    logic [6:0] text_char;  // hex digit of that nibble
  } grp_info_t;

  // lowercase hex digit of one nibble
  function automatic logic [6:0] hex_char(logic [3:0] nib);
    logic [6:0] res;
    if (nib < 4'd10) begin
      res = CharZero + {3'b000, nib};
    end else begin
      res = CharAlpha + {3'b000, nib};
    end
    return res;
  endfunction

endpackage

@@ rtl/ipv6c_group_unit.sv @@
// ipv6c_group_unit: shared group select, zero compare and hex digit unit
// picks one 16-bit group of the address and one of its nibbles per cycle
// depends on ipv6c_pkg
module ipv6c_group_unit (
  input  ipv6c_pkg::in_t       addr_i,
  input  logic [2:0]           grp_idx_i,
  input  logic [1:0]           dig_idx_i,
  input  logic                 lead_sel_i,
  output ipv6c_pkg::grp_info_t info_o
);

  logic [63:0] word;
  logic [15:0] grp_v;
  logic [1:0]  lead;
  logic [1:0]  pos;
  logic [3:0]  nib;

  // group select: group 0 is the top of the high half
  assign word = grp_idx_i[2] ? addr_i.addr_low : addr_i.addr_high;

  always_comb begin
    case (grp_idx_i[1:0])
      2'd0:    grp_v = word[63:48];
      2'd1:    grp_v = word[47:32];
      2'd2:    grp_v = word[31:16];
      default: grp_v = word[15:0];
    endcase
  end

  // first significant nibble, the last one when the group is zero
  always_comb begin
    if (grp_v[15:12] != 4'd0) begin
      lead = 2'd3;
    end else if (grp_v[11:8] != 4'd0) begin
      lead = 2'd2;
    end else if (grp_v[7:4] != 4'd0) begin
      lead = 2'd1;
    end else begin
      lead = 2'd0;
    end
  end

  assign pos = lead_sel_i ? lead : dig_idx_i;

  always_comb begin
    case (pos)
      2'd3:    nib = grp_v[15:12];
      2'd2:    nib = grp_v[11:8];
      2'd1:    nib = grp_v[7:4];
      default: nib = grp_v[3:0];
    endcase
  end

  assign info_o.zero      = (grp_v == 16'd0);
  assign info_o.pos       = pos;
  assign info_o.text_char = ipv6c_pkg::hex_char(nib);

endmodule

@@ rtl/ipv6_address_text_compressor.sv @@
// ipv6_address_text_compressor: rfc 5952 shortened text of one ipv6 address
// the first character follows the scan pass over the groups and the output register,
// then one character per cycle, 2 to 39 characters in all
// a new address is taken only once the scan pass and the character loop through the one
// shared group unit are done; busy is high meanwhile, receiver cannot stall
// reset: asynchronous active-low rst_ni returns the sequencer to idle
module ipv6_address_text_compressor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  ipv6c_pkg::in_t      addr_i,
  output logic                busy,
  output logic                result_valid_o,
  output ipv6c_pkg::out_t     result_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit
  } state_e;

  state_e               state_q, state_d;
  ipv6c_pkg::in_t       addr_q;
  logic [2:0]           grp_q, grp_d;
  logic [1:0]           dig_q, dig_d;
  logic [1:0]           col_q, col_d;
  logic                 run_q, run_d;
  logic                 first_q, first_d;
  logic [2:0]           run_start_q, run_start_d;
  logic [3:0]           run_len_q, run_len_d;
  logic [2:0]           best_start_q, best_start_d;
  logic [3:0]           best_len_q, best_len_d;
  logic                 valid_d;
  ipv6c_pkg::out_t      res_q, res_d;
  ipv6c_pkg::grp_info_t info;

  logic [3:0]           tgt;
  logic                 tgt_after_run;
  logic                 do_enter;
  logic [3:0]           run_end;
  logic [3:0]           len_inc;
  logic [2:0]           rs_cur;

  // shared group unit
  ipv6c_group_unit u_grp (
    .addr_i     (addr_q),
    .grp_idx_i  (grp_q),
    .dig_idx_i  (dig_q),
    .lead_sel_i (first_q),
    .info_o     (info)
  );

  assign busy = (state_q != StIdle);

  // sequencer next-state logic
  always_comb begin
    state_d      = state_q;
    grp_d        = grp_q;
    dig_d        = dig_q;
    col_d        = col_q;
    run_d        = run_q;
    first_d      = first_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    valid_d      = 1'b0;
    res_d        = res_q;
    tgt          = 4'd0;
    tgt_after_run = 1'b0;
    do_enter     = 1'b0;
    len_inc      = run_len_q + 4'd1;
    rs_cur       = (run_len_q == 4'd0) ? grp_q : run_start_q;
    run_end      = {1'b0, best_start_q} + best_len_q;

    case (state_q)
      StIdle: begin
        if (start) begin
          state_d      = StScan;
          grp_d        = 3'd0;
          run_start_d  = 3'd0;
          run_len_d    = 4'd0;
          best_start_d = 3'd0;
          best_len_d   = 4'd0;
        end
      end

      // one group per cycle: track the first longest zero run
      StScan: begin
        if (info.zero) begin
          run_len_d   = len_inc;
          run_start_d = rs_cur;
          if (len_inc > best_len_q) begin
            best_len_d   = len_inc;
            best_start_d = rs_cur;
          end
        end else begin
          run_len_d = 4'd0;
        end
        if (grp_q == 3'(ipv6c_pkg::NumGroups - 1)) begin
          state_d  = StEmit;
          tgt      = 4'd0;
          do_enter = 1'b1;
        end else begin
          grp_d = grp_q + 3'd1;
        end
      end

      // one character per cycle
      StEmit: begin
        valid_d = 1'b1;
        res_d.last_char = 1'b0;
        if (col_q != 2'd0) begin
          res_d.text_char = ipv6c_pkg::CharColon;
          if (col_q == 2'd1 && run_q) begin
            if (run_end == 4'(ipv6c_pkg::NumGroups)) begin
              res_d.last_char = 1'b1;
              state_d = StIdle;
            end else begin
              tgt           = run_end;
              tgt_after_run = 1'b1;
              do_enter      = 1'b1;
            end
          end else begin
            col_d = col_q - 2'd1;
          end
        end else begin
          res_d.text_char = info.text_char;
          first_d = 1'b0;
          if (info.pos == 2'd0) begin
            if (grp_q == 3'(ipv6c_pkg::NumGroups - 1)) begin
              res_d.last_char = 1'b1;
              state_d = StIdle;
            end else begin
              tgt      = {1'b0, grp_q} + 4'd1;
              do_enter = 1'b1;
            end
          end else begin
            dig_d = info.pos - 2'd1;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // set up the next group: either the compressed run or a plain group
    if (do_enter) begin
      grp_d   = tgt[2:0];
      first_d = 1'b1;
      dig_d   = 2'd0;
      if (best_len_d >= 4'd2 && tgt[2:0] == best_start_d) begin
        col_d = 2'd2;
        run_d = 1'b1;
      end else begin
        col_d = (tgt != 4'd0 && !tgt_after_run) ? 2'd1 : 2'd0;
        run_d = 1'b0;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      grp_q          <= 3'd0;
      dig_q          <= 2'd0;
      col_q          <= 2'd0;
      run_q          <= 1'b0;
      first_q        <= 1'b0;
      run_start_q    <= 3'd0;
      run_len_q      <= 4'd0;
      best_start_q   <= 3'd0;
      best_len_q     <= 4'd0;
      result_valid_o <= 1'b0;
      res_q          <= '0;
    end else begin
      state_q        <= state_d;
      grp_q          <= grp_d;
      dig_q          <= dig_d;
      col_q          <= col_d;
      run_q          <= run_d;
      first_q        <= first_d;
      run_start_q    <= run_start_d;
      run_len_q      <= run_len_d;
      best_start_q   <= best_start_d;
      best_len_q     <= best_len_d;
      result_valid_o <= valid_d;
      res_q          <= res_d;
    end
  end

  // input payload capture on transfer
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      addr_q <= addr_i;
    end
  end

  assign result_o = res_q;

`ifndef SYNTHESIS
  // the final character ends the burst
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_char |=> !result_valid_o)
    else $error("strobe after final character");

  // no character without work in progress
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !result_valid_o)
    else $error("character strobe while idle");

  // a double colon only comes from the compressed run
  a_dbl_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q == 2'd2 |-> run_q && best_len_q >= 4'd2)
    else $error("double colon without a zero run");

  // the longest zero run, compressed when at least two groups long, ends inside the address
  a_run_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> run_end <= 4'(ipv6c_pkg::NumGroups))
    else $error("zero run beyond the last group");
`endif

endmodule
